[rtl/core/gffp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid first-fit placer package
// Shared widths, default grid size and the command/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package gffp_pkg;

  // Default grid size.
  localparam int DEF_GRID_COLUMNS = 8;
  localparam int DEF_GRID_ROWS    = 15;

  // Fixed field widths of the item channels.
  localparam int MODE_W  = 1;
  localparam int SIZE_IN_W = 4;
  localparam int SLOT_W  = 7;
  localparam int COUNT_W = 7;

  // Working widths: a size compare covers grid sizes up to 32, and a cell
  // number covers up to 32 x 32 cells.
  localparam int SIZE_W = 6;
  localparam int CELL_W = 11;

  // Placement count saturates here.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // Request codes carried in the mode field.
  localparam logic MODE_PLACE = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a place request and start a scan
    logic clear;      // free every cell and zero the count
    logic scan_step;  // evaluate one grid row
    logic mark;       // mark the found footprint and count it
    logic emit;       // move the finished result to the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;   // incoming item is a clear request
    logic bad_size;   // incoming rectangle can never fit
    logic found;      // the current row completes a fitting footprint
    logic scan_last;  // the current row is the last row of the grid
  } status_t;

endpackage

[rtl/core/gffp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid first-fit placer channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface gffp_in_if;
  logic                            valid;
  logic                            ready;
  logic [gffp_pkg::MODE_W-1:0]     mode;
  logic [gffp_pkg::SIZE_IN_W-1:0]  item_width;
  logic [gffp_pkg::SIZE_IN_W-1:0]  item_height;

  modport source (output valid, output mode, output item_width, output item_height,
                  input ready);
  modport sink   (input valid, input mode, input item_width, input item_height,
                  output ready);
endinterface

interface gffp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          placed;
  logic [gffp_pkg::SLOT_W-1:0]   slot;
  logic [gffp_pkg::COUNT_W-1:0]  placed_count;

  modport source (output valid, output placed, output slot, output placed_count,
                  input ready);
  modport sink   (input valid, input placed, input slot, input placed_count,
                  output ready);
endinterface

[rtl/core/grid_first_fit_placer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid first-fit placer
// Keeps an occupancy map of a grid and places rectangles at the first free
// top-left cell in row-major order, or clears the grid on request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_chan   sink       mode, item_width, item_height
//  out_chan  source     placed, slot, placed_count
//
//  A place item passes through accept, a scan of up to GRID_ROWS grid rows (one
//  grid row per cycle through per-column free-run counters), marking and
//  hand-off. A clear item, or a size that can never fit, goes from accept
//  straight to hand-off.
//  Synchronous reset frees every cell and zeroes the count at once.
//  A result waits in the output register under stall while the next item is
//  accepted; that item stalls only at hand-off if the register is still full.
// ----------------------------------------------------------------------------
module grid_first_fit_placer_top #(
  parameter int GRID_COLUMNS = gffp_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = gffp_pkg::DEF_GRID_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  gffp_in_if.sink     in_chan,
  gffp_out_if.source  out_chan
);
  import gffp_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Sequencing.
  gffp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Map, scan and result registers.
  gffp_datapath #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_mode          (in_chan.mode),
    .in_item_width    (in_chan.item_width),
    .in_item_height   (in_chan.item_height),
    .out_placed       (out_chan.placed),
    .out_slot         (out_chan.slot),
    .out_placed_count (out_chan.placed_count)
  );

endmodule

[rtl/core/gffp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid first-fit placer controller
// State machine that sequences accept, row scan, marking and result hand-off,
// and owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
module gffp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gffp_pkg::status_t st,
  output gffp_pkg::cmd_t    cmd
);
  import gffp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_MARK = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  // Next state and commands.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (st.is_clear) begin
            cmd.clear = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = st.bad_size ? ST_EMIT : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.found) begin
          state_nxt = ST_MARK;
        end else if (st.scan_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // Wait until the output register is free or being drained.
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/core/gffp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid first-fit placer datapath
// Occupancy rows, per-column free-run counters for the row scan, footprint
// marking, the placement count and the result registers.
// ----------------------------------------------------------------------------
module gffp_datapath #(
  parameter int GRID_COLUMNS = gffp_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = gffp_pkg::DEF_GRID_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gffp_pkg::cmd_t                  cmd,
  output gffp_pkg::status_t               st,
  input  logic [gffp_pkg::MODE_W-1:0]     in_mode,
  input  logic [gffp_pkg::SIZE_IN_W-1:0]  in_item_width,
  input  logic [gffp_pkg::SIZE_IN_W-1:0]  in_item_height,
  output logic                            out_placed,
  output logic [gffp_pkg::SLOT_W-1:0]     out_slot,
  output logic [gffp_pkg::COUNT_W-1:0]    out_placed_count
);
  import gffp_pkg::*;

  localparam int XIDX_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int RIDX_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int RUN_W  = $clog2(GRID_ROWS + 1);
  localparam int WIDE_W = GRID_COLUMNS + 16;

  // Span of w bits starting at column x, with room above the grid so that a
  // span that runs past the last column can be seen.
  function automatic logic [WIDE_W-1:0] span_at(input logic [SIZE_IN_W-1:0] w,
                                                 input logic [XIDX_W-1:0]    x);
    logic [WIDE_W-1:0] base;
    base    = (WIDE_W'(1) << w) - WIDE_W'(1);
    span_at = base << x;
  endfunction

  // Occupancy map, one word per row.
  logic [GRID_COLUMNS-1:0] rows_r [GRID_ROWS];
  logic [COUNT_W-1:0]      count_r;
  logic [COUNT_W-1:0]      count_nxt;

  // Request and scan registers.
  logic [SIZE_IN_W-1:0] w_r;
  logic [SIZE_IN_W-1:0] h_r;
  logic [RIDX_W-1:0]    row_idx_r;
  logic [RUN_W-1:0]     run_r [GRID_COLUMNS];
  logic [RUN_W-1:0]     run_nxt [GRID_COLUMNS];
  logic [XIDX_W-1:0]    x_r;
  logic [RIDX_W-1:0]    y_r;

  // Pending result and output register.
  logic               pend_placed_r;
  logic [SLOT_W-1:0]  pend_slot_r;
  logic [COUNT_W-1:0] pend_count_r;
  logic               out_placed_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [GRID_COLUMNS-1:0] cur_row;
  logic [GRID_COLUMNS-1:0] fit;
  logic [GRID_COLUMNS-1:0] hit;
  logic                    found;
  logic [XIDX_W-1:0]       hit_x;
  logic [RIDX_W-1:0]       top_y;
  logic [WIDE_W-1:0]       mark_wide;
  logic [GRID_COLUMNS-1:0] mark_span;
  logic [CELL_W-1:0]       cell_num;

  // Size check on the incoming request.
  assign st.is_clear = (in_mode == MODE_CLEAR);
  assign st.bad_size = (in_item_width == '0) || (in_item_height == '0)
                    || ({2'b00, in_item_width}  > SIZE_W'(GRID_COLUMNS))
                    || ({2'b00, in_item_height} > SIZE_W'(GRID_ROWS));

  assign cur_row = rows_r[row_idx_r];

  // Per column: does the span at this column fit the grid and the current row,
  // and does its free run now reach the rectangle height.
  for (genvar gx = 0; gx < GRID_COLUMNS; gx++) begin : g_col
    logic [WIDE_W-1:0] span;
    logic [SIZE_W-1:0] run_inc;
    always_comb begin
      span       = span_at(w_r, XIDX_W'(gx));
      fit[gx]    = ((span[GRID_COLUMNS-1:0] & cur_row) == '0)
                && (span[WIDE_W-1:GRID_COLUMNS] == '0);
      run_inc    = SIZE_W'(run_r[gx]) + SIZE_W'(1);
      hit[gx]    = fit[gx] && (run_inc >= {2'b00, h_r});
      run_nxt[gx] = fit[gx] ? RUN_W'(run_inc) : '0;
    end
  end

  // Leftmost column whose footprint completes on this row.
  always_comb begin
    found = 1'b0;
    hit_x = '0;
    for (int x = GRID_COLUMNS - 1; x >= 0; x--) begin
      if (hit[x]) begin
        found = 1'b1;
        hit_x = XIDX_W'(x);
      end
    end
  end

  // The footprint's top row lies h-1 rows above the current one.
  assign top_y = RIDX_W'(SIZE_W'(row_idx_r) + SIZE_W'(1) - {2'b00, h_r});

  assign st.found     = found;
  assign st.scan_last = (row_idx_r == RIDX_W'(GRID_ROWS - 1));

  // Marking mask, cell number and saturating count.
  assign mark_wide = span_at(w_r, x_r);
  assign mark_span = mark_wide[GRID_COLUMNS-1:0];
  assign cell_num  = CELL_W'(x_r) + CELL_W'(y_r) * CELL_W'(GRID_COLUMNS);
  assign count_nxt = (count_r < COUNT_MAX) ? count_r + COUNT_W'(1) : count_r;

  // Occupancy map and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        rows_r[r] <= '0;
      end
      count_r <= '0;
    end else if (cmd.clear) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        rows_r[r] <= '0;
      end
      count_r <= '0;
    end else if (cmd.mark) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        if ((SIZE_W'(r) >= SIZE_W'(y_r))
            && (SIZE_W'(r) < SIZE_W'(y_r) + {2'b00, h_r})) begin
          rows_r[r] <= rows_r[r] | mark_span;
        end
      end
      count_r <= count_nxt;
    end
  end

  // Request capture and row scan.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r       <= in_item_width;
      h_r       <= in_item_height;
      row_idx_r <= '0;
      for (int x = 0; x < GRID_COLUMNS; x++) begin
        run_r[x] <= '0;
      end
    end else if (cmd.scan_step) begin
      if (found) begin
        x_r <= hit_x;
        y_r <= top_y;
      end else begin
        row_idx_r <= row_idx_r + RIDX_W'(1);
        for (int x = 0; x < GRID_COLUMNS; x++) begin
          run_r[x] <= run_nxt[x];
        end
      end
    end
  end

  // Pending result: no room by default, updated by a clear or a placement.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pend_placed_r <= 1'b0;
      pend_slot_r   <= '0;
      pend_count_r  <= count_r;
    end else if (cmd.clear) begin
      pend_placed_r <= 1'b1;
      pend_slot_r   <= '0;
      pend_count_r  <= '0;
    end else if (cmd.mark) begin
      pend_placed_r <= 1'b1;
      pend_slot_r   <= cell_num[SLOT_W-1:0];
      pend_count_r  <= count_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_placed_r <= pend_placed_r;
      out_slot_r   <= pend_slot_r;
      out_count_r  <= pend_count_r;
    end
  end

  assign out_placed       = out_placed_r;
  assign out_slot         = out_slot_r;
  assign out_placed_count = out_count_r;

endmodule

[rtl/core/gffp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid first-fit placer checker
// Port-level assertions on the handshakes and results of the placer.
// ----------------------------------------------------------------------------
module gffp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_placed,
  input logic [gffp_pkg::SLOT_W-1:0]     out_slot,
  input logic [gffp_pkg::COUNT_W-1:0]    out_placed_count
);
  import gffp_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_placed) && $stable(out_slot)
                               && $stable(out_placed_count))
    else $error("result payload changed while stalled");

  // One item is worked on at a time: accepting drops ready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // A failed placement reports cell zero.
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_placed |-> out_slot == '0)
    else $error("nonzero slot on a failed placement");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind grid_first_fit_placer_top gffp_checker u_gffp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_placed       (out_chan.placed),
  .out_slot         (out_chan.slot),
  .out_placed_count (out_chan.placed_count)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid first-fit placer testbench
// Drives place and clear requests into the placer and checks each result item
// against its table entry if known, else an in-bench grid occupancy model. A
// short table of directed requests covers the size extremes, full and empty
// grids and clears; random fill-and-clear episodes follow, with random gaps
// on both channels, a long result back-pressure stretch and a drain pause.
// ----------------------------------------------------------------------------
module tb;
  import gffp_pkg::*;

  localparam int COLS         = DEF_GRID_COLUMNS;
  localparam int ROWS         = DEF_GRID_ROWS;
  localparam int TABLE_ROWS   = 23;
  localparam int RANDOM_ITEMS = 1700;
  localparam int LONG_HOLD    = 250;
  localparam int MAX_REPORTS  = 10;

  // One request item as driven on the input channel.
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [SIZE_IN_W-1:0] width;
    logic [SIZE_IN_W-1:0] height;
  } request_t;

  // One result item as seen on the output channel.
  typedef struct packed {
    logic              placed;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] placements;
  } placement_t;

  // Directed stimulus row; the typed result is used only when known is set.
  typedef struct packed {
    request_t   req;
    logic       known;
    placement_t result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  gffp_in_if  in_if ();
  gffp_out_if out_if ();

  grid_first_fit_placer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #5 clk = ~clk;

  // Grid occupancy, one bit per column in each row, and the placement count.
  logic [COLS-1:0]    occupied [ROWS];
  logic [COUNT_W-1:0] placements;

  placement_t pending_results [$];

  int items_sent;
  int results_checked;
  int failures;
  int placements_made;
  int no_room_count;
  int clear_count;
  int long_hold_cycles;
  bit sender_calm;
  bit sink_calm;

  // Directed requests: size extremes, zero sizes, oversize, full grid, clears.
  directed_row_t directed_rows [TABLE_ROWS] = '{
    '{'{MODE_PLACE, 4'd1,  4'd1},  1'b1, '{1'b1, 7'd0, 7'd1}},
    '{'{MODE_PLACE, 4'd0,  4'd3},  1'b1, '{1'b0, 7'd0, 7'd1}},
    '{'{MODE_PLACE, 4'd3,  4'd0},  1'b1, '{1'b0, 7'd0, 7'd1}},
    '{'{MODE_PLACE, 4'd9,  4'd1},  1'b1, '{1'b0, 7'd0, 7'd1}},
    '{'{MODE_PLACE, 4'd15, 4'd15}, 1'b1, '{1'b0, 7'd0, 7'd1}},
    '{'{MODE_PLACE, 4'd1,  4'd15}, 1'b0, '0},
    '{'{MODE_CLEAR, 4'd15, 4'd15}, 1'b1, '{1'b1, 7'd0, 7'd0}},
    '{'{MODE_PLACE, 4'd8,  4'd15}, 1'b1, '{1'b1, 7'd0, 7'd1}},
    '{'{MODE_PLACE, 4'd1,  4'd1},  1'b1, '{1'b0, 7'd0, 7'd1}},
    '{'{MODE_CLEAR, 4'd0,  4'd0},  1'b1, '{1'b1, 7'd0, 7'd0}},
    '{'{MODE_PLACE, 4'd8,  4'd1},  1'b1, '{1'b1, 7'd0, 7'd1}},
    '{'{MODE_PLACE, 4'd1,  4'd14}, 1'b0, '0},
    '{'{MODE_PLACE, 4'd7,  4'd14}, 1'b0, '0},
    '{'{MODE_PLACE, 4'd1,  4'd1},  1'b0, '0},
    '{'{MODE_CLEAR, 4'd5,  4'd10}, 1'b1, '{1'b1, 7'd0, 7'd0}},
    '{'{MODE_PLACE, 4'd1,  4'd15}, 1'b0, '0},
    '{'{MODE_PLACE, 4'd7,  4'd15}, 1'b0, '0},
    '{'{MODE_PLACE, 4'd2,  4'd1},  1'b0, '0},
    '{'{MODE_CLEAR, 4'd1,  4'd1},  1'b1, '{1'b1, 7'd0, 7'd0}},
    '{'{MODE_PLACE, 4'd3,  4'd5},  1'b0, '0},
    '{'{MODE_PLACE, 4'd5,  4'd5},  1'b0, '0},
    '{'{MODE_PLACE, 4'd4,  4'd3},  1'b0, '0},
    '{'{MODE_PLACE, 4'd8,  4'd8},  1'b0, '0}
  };

  // Applies one request to the grid model and returns the result it causes.
  // Candidates are scanned row-major; the first fully free footprint wins.
  function automatic placement_t apply_request(request_t req);
    placement_t   res;
    int unsigned  span;
    bit           fits;
    res = '0;
    if (req.mode == MODE_CLEAR) begin
      foreach (occupied[r]) occupied[r] = '0;
      placements = '0;
      clear_count++;
      res.placed = 1'b1;
      return res;
    end
    res.placements = placements;
    if (req.width == 0 || req.height == 0 || req.width > COLS || req.height > ROWS) begin
      no_room_count++;
      return res;
    end
    for (int y = 0; y + req.height <= ROWS; y++) begin
      for (int x = 0; x + req.width <= COLS; x++) begin
        span = ((32'd1 << req.width) - 32'd1) << x;
        fits = 1'b1;
        for (int r = 0; r < req.height; r++) begin
          if ((occupied[y + r] & span[COLS-1:0]) != '0) fits = 1'b0;
        end
        if (fits) begin
          for (int r = 0; r < req.height; r++) begin
            occupied[y + r] = occupied[y + r] | span[COLS-1:0];
          end
          if (placements < COUNT_MAX) placements = placements + 1'b1;
          placements_made++;
          res.placed     = 1'b1;
          res.slot       = SLOT_W'(x + y * COLS);
          res.placements = placements;
          return res;
        end
      end
    end
    no_room_count++;
    return res;
  endfunction

  // Wait in cycles before the next item on either side; calm means no gaps.
  function automatic int draw_wait(bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Random request: mostly small rectangles that fill the grid, some of any
  // legal size, some with any 4-bit size, and a few stray clears.
  function automatic request_t random_request();
    request_t req;
    int       pick;
    pick       = $urandom_range(0, 99);
    req.mode   = MODE_PLACE;
    req.width  = SIZE_IN_W'($urandom_range(1, 3));
    req.height = SIZE_IN_W'($urandom_range(1, 4));
    if (pick < 3) begin
      req.mode   = MODE_CLEAR;
      req.width  = SIZE_IN_W'($urandom_range(0, 15));
      req.height = SIZE_IN_W'($urandom_range(0, 15));
    end else if (pick < 13) begin
      req.width  = SIZE_IN_W'($urandom_range(0, 15));
      req.height = SIZE_IN_W'($urandom_range(0, 15));
    end else if (pick < 30) begin
      req.width  = SIZE_IN_W'($urandom_range(1, COLS));
      req.height = SIZE_IN_W'($urandom_range(1, ROWS));
    end
    return req;
  endfunction

  // Offers one request after a gap, waits for it to be taken and records the
  // result it should cause. Starts and ends at a falling edge.
  task automatic offer_request(request_t req, logic known, placement_t typed);
    placement_t predicted;
    int         gap;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.mode        = req.mode;
    in_if.item_width  = req.width;
    in_if.item_height = req.height;
    in_if.valid       = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    predicted = apply_request(req);
    pending_results.push_back(known ? typed : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  // Compares one accepted result item with the oldest pending expectation.
  task automatic check_result();
    placement_t got;
    placement_t want;
    got = '{out_if.placed, out_if.slot, out_if.placed_count};
    results_checked++;
    if (pending_results.size() == 0) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("[%0t] unexpected result: placed=%0d slot=%0d count=%0d",
                 $realtime, got.placed, got.slot, got.placements);
    end else begin
      want = pending_results.pop_front();
      if (got.placed !== want.placed || got.slot !== want.slot ||
          got.placements !== want.placements) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display({"[%0t] mismatch: expected placed=%0d slot=%0d count=%0d,",
                    " got placed=%0d slot=%0d count=%0d"},
                   $realtime, want.placed, want.slot, want.placements,
                   got.placed, got.slot, got.placements);
      end
    end
  endtask

  // Result side: random stalls per item, plus a long hold-off on request.
  initial begin
    int sink_wait;
    sink_wait   = 0;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold_cycles > 0) begin
        out_if.ready = 1'b0;
        repeat (long_hold_cycles) @(negedge clk);
        long_hold_cycles = 0;
      end
      out_if.ready = (sink_wait == 0);
      if (sink_wait > 0) sink_wait--;
      @(posedge clk);
      if (out_if.valid === 1'b1 && out_if.ready) begin
        check_result();
        sink_wait = draw_wait(sink_calm);
      end
    end
  end

  // Stimulus: reset, directed table, then random fill-and-clear episodes.
  initial begin
    request_t req;
    int       episode;
    int       run_len;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.mode        = MODE_PLACE;
    in_if.item_width  = '0;
    in_if.item_height = '0;
    items_sent        = 0;
    results_checked   = 0;
    failures          = 0;
    placements_made   = 0;
    no_room_count     = 0;
    clear_count       = 0;
    long_hold_cycles  = 0;
    sender_calm       = 1'b0;
    sink_calm         = 1'b0;
    episode           = 0;
    foreach (occupied[r]) occupied[r] = '0;
    placements = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].result);
    end

    while (items_sent < TABLE_ROWS + RANDOM_ITEMS) begin
      episode++;
      sender_calm = ($urandom_range(0, 3) == 0);
      sink_calm   = ($urandom_range(0, 3) == 0);
      // Hold results back while requests keep coming, so the input stalls.
      if (episode == 4) begin
        sender_calm      = 1'b1;
        long_hold_cycles = LONG_HOLD;
      end
      // Let the block drain completely before going on; the last item is
      // already taken, so stop offering it.
      if (episode % 12 == 8) begin
        in_if.valid = 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
      req.mode   = MODE_CLEAR;
      req.width  = SIZE_IN_W'($urandom_range(0, 15));
      req.height = SIZE_IN_W'($urandom_range(0, 15));
      offer_request(req, 1'b0, '0);
      run_len = $urandom_range(10, 50);
      repeat (run_len) offer_request(random_request(), 1'b0, '0);
    end
    in_if.valid = 1'b0;

    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d requests in %0d episodes: %0d placements,",
             items_sent, episode, placements_made);
    $display("%0d no-room answers and %0d clears; compared %0d results, %0d failures.",
             no_room_count, clear_count, results_checked, failures);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending.", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
